@@ hdl/lsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and constants of the lease slot allocator.
// ----------------------------------------------------------------------------
package lsa_pkg;

   localparam int MAX_SLOTS_DEF  = 16;
   localparam int TIME_W         = 31;
   localparam int WORD_W         = 2 * TIME_W + 1;
   localparam int CSR_W          = 5;
   localparam int SLOT_W         = 4;
   localparam int COUNT_W        = 5;
   localparam logic [CSR_W-1:0] ACTIVE_RESET = 5'd16;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } walk_state_type;

   typedef struct packed {
      logic               status;
      logic [SLOT_W-1:0]  slot_index;
      logic [COUNT_W-1:0] free_count;
      logic [COUNT_W-1:0] freed_count;
   } result_type;

endpackage

@@ hdl/lsa_lease_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_lease_mem
// Slot table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lsa_lease_mem #(
   parameter int DEPTH = lsa_pkg::MAX_SLOTS_DEF,
   parameter int AW    = 4,
   parameter int WIDTH = lsa_pkg::WORD_W
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lsa_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_walker
// Sequencer: clears the table after reset, then walks the active slots once
// per item, claiming or expiring leases and counting free slots.
// ----------------------------------------------------------------------------
module lsa_walker #(
   parameter int MAX_SLOTS = lsa_pkg::MAX_SLOTS_DEF,
   parameter int AW        = 4,
   parameter int CW        = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [CW-1:0]              live_slots,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_command,
   input  logic [lsa_pkg::TIME_W-1:0] req_current_time,
   input  logic [lsa_pkg::TIME_W-1:0] req_lease_length,
   input  logic                       out_free,
   output logic                       done,
   output lsa_pkg::result_type        result,
   output logic                       rd_en,
   output logic [AW-1:0]              rd_addr,
   input  logic [lsa_pkg::WORD_W-1:0] rd_data,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [lsa_pkg::WORD_W-1:0] wr_data
);

   localparam int TW = lsa_pkg::TIME_W;

   lsa_pkg::walk_state_type state_ff, state_in;

   logic [CW-1:0] idx_ff, idx_in;
   logic          proc_valid_ff, proc_valid_in;
   logic [AW-1:0] proc_addr_ff, proc_addr_in;
   logic          found_ff, found_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [CW-1:0] free_ff, free_in;
   logic [CW-1:0] freed_ff, freed_in;
   logic          cmd_ff;
   logic [TW-1:0] now_ff;
   logic [TW-1:0] len_ff;

   logic          accept;
   logic          last_idx;
   logic          occ;
   logic [TW-1:0] start;
   logic [TW-1:0] length;
   logic [TW:0]   elapsed;
   logic          expired;
   logic          claim;
   logic          release_slot;
   logic          free_after;

   assign accept   = req_valid && !req_stall;
   assign last_idx = (idx_ff == live_slots - CW'(1));

   assign occ     = rd_data[lsa_pkg::WORD_W-1];
   assign start   = rd_data[2*TW-1:TW];
   assign length  = rd_data[TW-1:0];
   assign elapsed = {1'b0, now_ff} - {1'b0, start};
   assign expired = !elapsed[TW] && (elapsed[TW-1:0] >= length);

   assign claim        = proc_valid_ff && (cmd_ff == lsa_pkg::CMD_ALLOC) && !occ && !found_ff;
   assign release_slot = proc_valid_ff && (cmd_ff == lsa_pkg::CMD_TICK) && occ && expired;
   assign free_after   = (!occ && !claim) || release_slot;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsa_pkg::ST_CLEAR: begin
            if (idx_ff == CW'(MAX_SLOTS - 1)) state_in = lsa_pkg::ST_IDLE;
         end
         lsa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (live_slots == '0) ? lsa_pkg::ST_DONE : lsa_pkg::ST_WALK;
            end
         end
         lsa_pkg::ST_WALK: begin
            if (last_idx) state_in = lsa_pkg::ST_DRAIN;
         end
         lsa_pkg::ST_DRAIN: state_in = lsa_pkg::ST_DONE;
         lsa_pkg::ST_DONE: begin
            if (out_free) state_in = lsa_pkg::ST_IDLE;
         end
         default: state_in = lsa_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall     = (state_ff != lsa_pkg::ST_IDLE);
      done          = (state_ff == lsa_pkg::ST_DONE) && out_free;
      rd_en         = (state_ff == lsa_pkg::ST_WALK);
      rd_addr       = idx_ff[AW-1:0];
      wr_en         = claim || release_slot;
      wr_addr       = proc_addr_ff;
      wr_data       = claim ? {1'b1, now_ff, len_ff} : {1'b0, start, length};
      idx_in        = idx_ff;
      proc_valid_in = rd_en;
      proc_addr_in  = idx_ff[AW-1:0];
      found_in      = found_ff || claim;
      slot_in       = claim ? proc_addr_ff : slot_ff;
      free_in       = free_ff + CW'(proc_valid_ff && free_after);
      freed_in      = freed_ff + CW'(release_slot);

      unique case (state_ff)
         lsa_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = '0;
            idx_in  = idx_ff + CW'(1);
         end
         lsa_pkg::ST_IDLE: begin
            idx_in   = '0;
            found_in = 1'b0;
            slot_in  = '0;
            free_in  = '0;
            freed_in = '0;
         end
         lsa_pkg::ST_WALK: idx_in = idx_ff + CW'(1);
         default: ;
      endcase

      result.status      = ((cmd_ff == lsa_pkg::CMD_ALLOC) && !found_ff) ?
                           lsa_pkg::STATUS_FULL : lsa_pkg::STATUS_OK;
      result.slot_index  = lsa_pkg::SLOT_W'(slot_ff);
      result.free_count  = lsa_pkg::COUNT_W'(free_ff);
      result.freed_count = lsa_pkg::COUNT_W'(freed_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lsa_pkg::ST_CLEAR;
         idx_ff        <= '0;
         proc_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         slot_ff       <= '0;
         free_ff       <= '0;
         freed_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         proc_valid_ff <= proc_valid_in;
         found_ff      <= found_in;
         slot_ff       <= slot_in;
         free_ff       <= free_in;
         freed_ff      <= freed_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_addr_ff <= proc_addr_in;
      if (accept) begin
         cmd_ff <= req_command;
         now_ff <= req_current_time;
         len_ff <= req_lease_length;
      end
   end

endmodule

@@ hdl/lease_slot_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lease_slot_allocator_unit
// Lease slot table with allocate and tick-expire commands.
// ----------------------------------------------------------------------------
// Every item, allocate or tick, walks the active slots (at most MAX_SLOTS)
// once through the slot memory, one slot per cycle; the memory registers
// each slot's read data before the slot is processed, and with no active
// slot the walk is skipped. After reset a clearing pass writes every slot
// free, during which no item is taken; configuration writes are always
// taken. A finished result waits in an output register while the next item
// is accepted.
// ----------------------------------------------------------------------------
module lease_slot_allocator_unit #(
   parameter int MAX_SLOTS = lsa_pkg::MAX_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lsa_pkg::CSR_W-1:0]   csr_active_slots,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [lsa_pkg::TIME_W-1:0]  req_current_time,
   input  logic [lsa_pkg::TIME_W-1:0]  req_lease_length,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_status,
   output logic [lsa_pkg::SLOT_W-1:0]  rsp_slot_index,
   output logic [lsa_pkg::COUNT_W-1:0] rsp_free_count,
   output logic [lsa_pkg::COUNT_W-1:0] rsp_freed_count
);

   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = (AW + 1 > lsa_pkg::CSR_W) ? AW + 1 : lsa_pkg::CSR_W;

   logic [lsa_pkg::CSR_W-1:0] active_ff;
   logic [CW-1:0]             active_ext;
   logic [CW-1:0]             live_slots;

   logic                      rsp_valid_ff;
   lsa_pkg::result_type       rsp_ff;
   logic                      out_free;
   logic                      done;
   lsa_pkg::result_type       result;

   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [lsa_pkg::WORD_W-1:0] rd_data;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [lsa_pkg::WORD_W-1:0] wr_data;

   assign csr_ready  = 1'b1;
   assign active_ext = CW'(active_ff);
   assign live_slots = (active_ext > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : active_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= lsa_pkg::ACTIVE_RESET;
      end else if (csr_valid && csr_ready) begin
         active_ff <= csr_active_slots;
      end
   end

   lsa_walker #(
      .MAX_SLOTS (MAX_SLOTS),
      .AW        (AW),
      .CW        (CW)
   ) u_walker (
      .clock            (clock),
      .reset            (reset),
      .live_slots       (live_slots),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_current_time (req_current_time),
      .req_lease_length (req_lease_length),
      .out_free         (out_free),
      .done             (done),
      .result           (result),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

   lsa_lease_mem #(
      .DEPTH (MAX_SLOTS),
      .AW    (AW),
      .WIDTH (lsa_pkg::WORD_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // hold the result until taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_slot_index  = rsp_ff.slot_index;
   assign rsp_free_count  = rsp_ff.free_count;
   assign rsp_freed_count = rsp_ff.freed_count;

endmodule
